>>> src/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants of the crank tachometer: field widths, register
// codes and reset values, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int TIME_W    = 32;
  localparam int SPEED_W   = 16;
  localparam int HELD_W    = 3;
  localparam int TEETH_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEETH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVR_EN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OVR_VAL  = 3'd4;

  // register reset values
  localparam logic [TEETH_W-1:0] TEETH_RESET   = 8'd1;
  localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd250000;
  localparam logic [TIME_W-1:0]  SCALE_RESET   = 32'd6000000;

  localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;
  localparam logic [HELD_W-1:0]  HELD_MAX  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_SPAN,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } crt_state_t;

  // source of the speed result
  typedef enum logic [1:0] {
    RES_OVERRIDE,
    RES_ZERO,
    RES_FULL,
    RES_QUOT
  } crt_res_t;

  typedef struct packed {
    logic     edge_en;
    logic     read_start;
    logic     age_chk;
    logic     rd_oldest;
    logic     span_load;
    logic     div_init;
    logic     div_step;
    logic     res_load;
    crt_res_t res_sel;
    logic     out_load;
  } crt_cmd_t;

  typedef struct packed {
    logic override;
    logic count_zero;
    logic few;
    logic stale;
    logic span_full;
    logic div_last;
    logic out_free;
  } crt_status_t;

endpackage

>>> src/crt_if.sv
// ----------------------------------------------------------------------------
// crt_in_if / crt_out_if
// Valid/ready channels of the tachometer: tooth edge and read requests in,
// speed results out.
// ----------------------------------------------------------------------------
interface crt_in_if;
  import crt_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [TIME_W-1:0] time_us;

  modport source (output valid, output command, output time_us, input ready);
  modport sink   (input valid, input command, input time_us, output ready);
endinterface

interface crt_out_if;
  import crt_pkg::*;

  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_value;
  logic               stale_cleared;
  logic [HELD_W-1:0]  stamps_held;

  modport source (output valid, output speed_value, output stale_cleared,
                  output stamps_held, input ready);
  modport sink   (input valid, input speed_value, input stale_cleared,
                  input stamps_held, output ready);
endinterface

>>> src/crank_rpm_tachometer_core.sv
// Tooth edges are accepted back to back while no read is in progress.
// A read with override on or an empty ring loads its result on acceptance; a full
// read loads it after stamp fetch, stale check, span/product, saturation check and
// the 16-step restoring divider. Either waits for a free output register.
// The next item is taken the cycle after the result enters the output register.
// Reset (synchronous, active high) empties the ring and restores register defaults.
// ----------------------------------------------------------------------------
// crank_rpm_tachometer_core
// Period-based tachometer: counts tooth edges into revolution stamps held in a
// small ring and answers reads with the scaled rate over the held interval.
// ----------------------------------------------------------------------------
module crank_rpm_tachometer_core #(
  parameter int RING_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  crt_in_if.sink                        in_ch,
  crt_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [crt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crt_pkg::CFG_W-1:0]     cfg_data
);
  import crt_pkg::*;

  crt_cmd_t    cmd;
  crt_status_t status;

  // sequencing
  crt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // storage and arithmetic
  crt_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_time_us        (in_ch.time_us),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_speed_value   (out_ch.speed_value),
    .out_stale_cleared (out_ch.stale_cleared),
    .out_stamps_held   (out_ch.stamps_held)
  );

endmodule

>>> src/crt_ctrl.sv
// ----------------------------------------------------------------------------
// crt_ctrl
// Controller of the tachometer: sequences a read through stamp fetch, stale
// check, span and product, saturation check and the 16-step divider.
// ----------------------------------------------------------------------------
module crt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  input  crt_pkg::crt_status_t status,
  output crt_pkg::crt_cmd_t    cmd
);
  import crt_pkg::*;

  crt_state_t state;
  crt_state_t state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_command) begin
          if (status.override || status.count_zero) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_AGE;
          end
        end
      end
      ST_AGE: begin
        if (status.stale || status.few) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SPAN;
        end
      end
      ST_SPAN:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (status.span_full) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.res_sel = RES_ZERO;
    case (state)
      ST_IDLE: begin
        cmd.edge_en    = accept && !in_command;
        cmd.read_start = accept && in_command;
        if (accept && in_command) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = status.override ? RES_OVERRIDE : RES_ZERO;
        end
      end
      ST_AGE: begin
        cmd.age_chk   = 1'b1;
        cmd.rd_oldest = 1'b1;
      end
      ST_SPAN: begin
        cmd.span_load = 1'b1;
      end
      ST_CHECK: begin
        if (status.span_full) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_FULL;
        end else begin
          cmd.div_init = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_QUOT;
        end
      end
      ST_FINISH: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> src/crt_datapath.sv
// ----------------------------------------------------------------------------
// crt_datapath
// Datapath of the tachometer: configuration registers, tooth prescaler, stamp
// ring memory with its indexes, span and product registers, restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module crt_datapath #(
  parameter int RING_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [crt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crt_pkg::CFG_W-1:0]         cfg_data,
  input  logic [crt_pkg::TIME_W-1:0]        in_time_us,
  input  crt_pkg::crt_cmd_t                 cmd,
  output crt_pkg::crt_status_t              status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [crt_pkg::SPEED_W-1:0]       out_speed_value,
  output logic                              out_stale_cleared,
  output logic [crt_pkg::HELD_W-1:0]        out_stamps_held
);
  import crt_pkg::*;

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int NUM_W = CNT_W + TIME_W;
  localparam int CMP_W = (NUM_W > TIME_W + SPEED_W) ? NUM_W : TIME_W + SPEED_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

  // configuration
  logic [TEETH_W-1:0] teeth_per_rev;
  logic [TIME_W-1:0]  stale_timeout_us;
  logic [TIME_W-1:0]  rate_scale;
  logic               override_enable;
  logic [SPEED_W-1:0] override_value;

  // ring state
  logic [TIME_W-1:0]  stamp_ring [RING_DEPTH];
  logic [TIME_W-1:0]  rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   newest_index;
  logic [IDX_W-1:0]   newest_index_next;
  logic [IDX_W-1:0]   oldest_index;
  logic [CNT_W-1:0]   stamp_count;
  logic [TEETH_W-1:0] tooth_counter;
  logic [TEETH_W-1:0] tooth_inc;
  logic               stamp_fire;

  // read working registers
  logic [TIME_W-1:0]  read_time;
  logic [TIME_W-1:0]  newest_stamp;
  logic [TIME_W-1:0]  span;
  logic [NUM_W-1:0]   num;
  logic [TIME_W-1:0]  rem;
  logic [SPEED_W-1:0] quot;
  logic [SPEED_W-1:0] quot_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [TIME_W-1:0]  age;
  logic [TIME_W:0]    trial;
  logic [TIME_W:0]    diff;
  logic               trial_ge;
  logic [HELD_W-1:0]  held_sat;

  // result registers
  logic [SPEED_W-1:0] speed_res;
  logic               cleared_res;
  logic [HELD_W-1:0]  held_res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      teeth_per_rev    <= TEETH_RESET;
      stale_timeout_us <= TIMEOUT_RESET;
      rate_scale       <= SCALE_RESET;
      override_enable  <= 1'b0;
      override_value   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEETH:   teeth_per_rev    <= cfg_data[TEETH_W-1:0];
        CFG_TIMEOUT: stale_timeout_us <= cfg_data[TIME_W-1:0];
        CFG_SCALE:   rate_scale       <= cfg_data[TIME_W-1:0];
        CFG_OVR_EN:  override_enable  <= cfg_data[0];
        CFG_OVR_VAL: override_value   <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // prescaler and next write slot
  assign tooth_inc  = tooth_counter + TEETH_W'(1);
  assign stamp_fire = cmd.edge_en && (tooth_inc >= teeth_per_rev);

  always_comb begin
    newest_index_next = newest_index;
    if (stamp_count != '0) begin
      newest_index_next = (newest_index == IDX_LAST) ? '0 : newest_index + IDX_W'(1);
    end
  end

  // ring indexes, count and prescaler
  always_ff @(posedge clk) begin
    if (rst) begin
      tooth_counter <= '0;
      newest_index  <= '0;
      oldest_index  <= '0;
      stamp_count   <= '0;
    end else if (cmd.edge_en) begin
      tooth_counter <= stamp_fire ? '0 : tooth_inc;
      if (stamp_fire) begin
        newest_index <= newest_index_next;
        if (stamp_count == CNT_FULL) begin
          oldest_index <= (oldest_index == IDX_LAST) ? '0 : oldest_index + IDX_W'(1);
        end else begin
          stamp_count <= stamp_count + CNT_W'(1);
        end
      end
    end else if (cmd.age_chk && status.stale) begin
      newest_index <= '0;
      oldest_index <= '0;
      stamp_count  <= '0;
    end
  end

  // stamp memory, one write and one registered read port
  assign rd_addr = cmd.rd_oldest ? oldest_index : newest_index;

  always_ff @(posedge clk) begin
    if (stamp_fire) begin
      stamp_ring[newest_index_next] <= in_time_us;
    end
    rd_data <= stamp_ring[rd_addr];
  end

  // stale test and saturated count
  assign age      = read_time - rd_data;
  assign held_sat = (32'(stamp_count) > 32'(HELD_MAX)) ? HELD_MAX : HELD_W'(stamp_count);

  // divider step
  assign trial     = {rem, num[SPEED_W-1]};
  assign diff      = trial - {1'b0, span};
  assign trial_ge  = (trial >= {1'b0, span});
  assign quot_next = {quot[SPEED_W-2:0], trial_ge};

  // read working registers and divider
  always_ff @(posedge clk) begin
    if (cmd.read_start) begin
      read_time <= in_time_us;
    end
    if (cmd.age_chk) begin
      newest_stamp <= rd_data;
    end
    if (cmd.span_load) begin
      span <= newest_stamp - rd_data;
      num  <= NUM_W'(stamp_count - CNT_W'(1)) * NUM_W'(rate_scale);
    end else if (cmd.div_init) begin
      rem     <= TIME_W'(num >> SPEED_W);
      div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      num     <= {num[NUM_W-2:0], 1'b0};
      quot    <= quot_next;
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.read_start) begin
      cleared_res <= 1'b0;
      held_res    <= '0;
    end else if (cmd.age_chk) begin
      cleared_res <= status.stale;
      held_res    <= status.stale ? '0 : held_sat;
    end
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_OVERRIDE: speed_res <= override_value;
        RES_ZERO:     speed_res <= '0;
        RES_FULL:     speed_res <= SPEED_MAX;
        RES_QUOT:     speed_res <= quot_next;
        default:      speed_res <= '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_speed_value   <= speed_res;
      out_stale_cleared <= cleared_res;
      out_stamps_held   <= held_res;
    end
  end

  // status to the controller
  always_comb begin
    status.override   = override_enable;
    status.count_zero = (stamp_count == '0);
    status.few        = (32'(stamp_count) < 32'd2);
    status.stale      = (age > stale_timeout_us);
    status.span_full  = (span == '0) ||
                        (CMP_W'(num) >= CMP_W'({span, {SPEED_W{1'b0}}}));
    status.div_last   = (div_cnt == '0);
    status.out_free   = !out_valid || out_ready;
  end

endmodule
